### rtl/core/svfd_pkg.sv
// ----------------------------------------------------------------------------
// svfd_pkg
// Shared constants and controller/datapath interface types for the sorter.
// ----------------------------------------------------------------------------
package svfd_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 64;
    localparam int POS_W         = 6;

    // commands from controller to datapath
    typedef struct packed {
        logic insert;      // load one request into the insertion chain
        logic clear_step;  // zero the step counter
        logic rotate;      // rotate the valid part of the chain by one cell
        logic emit;        // register cell 0 as a result
        logic finish;      // empty the chain and clear the set state
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;        // chain holds MAX_ITEMS entries
        logic posc_zero;   // no stored value has its top bit clear
        logic new_pos;     // incoming value has its top bit clear
        logic skip_last;   // last skip step of the signed rotation
        logic emit_last;   // last result of the set
    } dp_status_t;

endpackage

### rtl/core/svfd_ctrl.sv
// ----------------------------------------------------------------------------
// svfd_ctrl
// Sequencer: load, signed-order pre-rotation, and result emission.
// ----------------------------------------------------------------------------
module svfd_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   set_end,
    input  logic                   cfg_write,
    input  logic                   cfg_data,
    input  svfd_pkg::dp_status_t   status,
    output svfd_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);
    import svfd_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_SKIP = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   signed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            signed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                signed_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    cmd.insert = 1'b1;
                    if (set_end)
                    begin
                        cmd.clear_step = 1'b1;
                        // signed order: non-negative values sit first in the
                        // unsigned chain, so rotate them past the negatives
                        if (signed_reg &&
                            (!status.posc_zero || (status.new_pos && !status.full)))
                        begin
                            state_next = S_SKIP;
                        end
                        else
                        begin
                            state_next = S_EMIT;
                        end
                    end
                end
            end
            S_SKIP:
            begin
                cmd.rotate = 1'b1;
                if (status.skip_last)
                begin
                    cmd.clear_step = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.rotate = 1'b1;
                cmd.emit   = 1'b1;
                if (status.emit_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign busy = (state_reg != S_LOAD);

endmodule

### rtl/core/svfd_datapath.sv
// ----------------------------------------------------------------------------
// svfd_datapath
// Insertion chain kept in unsigned order, set counters and result register.
// ----------------------------------------------------------------------------
module svfd_datapath
#(
    parameter int MAX_ITEMS = svfd_pkg::MAX_ITEMS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [svfd_pkg::VALUE_W-1:0]  item_value,
    input  svfd_pkg::ctrl_cmd_t           cmd,
    output svfd_pkg::dp_status_t          status,
    output logic                          result_valid,
    output logic [svfd_pkg::VALUE_W-1:0]  sorted_value,
    output logic [svfd_pkg::POS_W-1:0]    arrival_position,
    output logic                          run_end,
    output logic                          duplicate_found,
    output logic                          overflow
);
    import svfd_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [VALUE_W-1:0] val_reg  [MAX_ITEMS];
    logic [VALUE_W-1:0] val_next [MAX_ITEMS];
    logic [POS_W-1:0]   pos_reg  [MAX_ITEMS];
    logic [POS_W-1:0]   pos_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] vld_reg, vld_next;
    logic [MAX_ITEMS-1:0] ins;

    logic [CW-1:0]      count_reg, posc_reg, step_reg;
    logic               ovf_reg, dup_reg;
    logic [VALUE_W-1:0] prev_reg;
    logic               do_insert, dup_now;
    logic [POS_W-1:0]   new_pos_tag;

    logic               valid_out_reg;
    logic [VALUE_W-1:0] value_out_reg;
    logic [POS_W-1:0]   pos_out_reg;
    logic               run_end_reg, dup_out_reg, ovf_out_reg;

    assign do_insert   = cmd.insert && !status.full;
    assign new_pos_tag = POS_W'(count_reg);

    // one cell per entry; new values go in after any equal ones
    for (genvar g = 0; g < MAX_ITEMS; g++)
    begin : g_cell
        logic [VALUE_W-1:0] shift_val, rot_val;
        logic [POS_W-1:0]   shift_pos, rot_pos;
        logic               shift_ins, shift_vld;

        assign ins[g] = !vld_reg[g] || (val_reg[g] > item_value);

        if (g == 0)
        begin : g_head
            assign shift_val = item_value;
            assign shift_pos = new_pos_tag;
            assign shift_ins = 1'b0;
            assign shift_vld = 1'b1;
        end
        else
        begin : g_body
            assign shift_val = val_reg[g-1];
            assign shift_pos = pos_reg[g-1];
            assign shift_ins = ins[g-1];
            assign shift_vld = vld_reg[g-1];
        end

        if (g == MAX_ITEMS - 1)
        begin : g_tail
            assign rot_val = val_reg[0];
            assign rot_pos = pos_reg[0];
        end
        else
        begin : g_mid
            // wrap at the end of the valid region
            assign rot_val = vld_reg[g+1] ? val_reg[g+1] : val_reg[0];
            assign rot_pos = vld_reg[g+1] ? pos_reg[g+1] : pos_reg[0];
        end

        always_comb
        begin
            val_next[g] = val_reg[g];
            pos_next[g] = pos_reg[g];
            vld_next[g] = vld_reg[g];
            if (do_insert)
            begin
                if (ins[g])
                begin
                    if (shift_ins)
                    begin
                        val_next[g] = shift_val;
                        pos_next[g] = shift_pos;
                    end
                    else
                    begin
                        val_next[g] = item_value;
                        pos_next[g] = new_pos_tag;
                    end
                end
                vld_next[g] = vld_reg[g] || shift_vld;
            end
            else if (cmd.rotate)
            begin
                val_next[g] = rot_val;
                pos_next[g] = rot_pos;
            end
            if (cmd.finish)
            begin
                vld_next[g] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            val_reg[i] <= val_next[i];
            pos_reg[i] <= pos_next[i];
        end
        if (cmd.emit)
        begin
            prev_reg      <= val_reg[0];
            value_out_reg <= val_reg[0];
            pos_out_reg   <= pos_reg[0];
            run_end_reg   <= status.emit_last;
            dup_out_reg   <= status.emit_last && dup_now;
            ovf_out_reg   <= status.emit_last && ovf_reg;
        end
    end

    assign dup_now = dup_reg || ((step_reg != '0) && (prev_reg == val_reg[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            count_reg     <= '0;
            posc_reg      <= '0;
            step_reg      <= '0;
            ovf_reg       <= 1'b0;
            dup_reg       <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            valid_out_reg <= cmd.emit;
            if (cmd.finish)
            begin
                count_reg <= '0;
                posc_reg  <= '0;
                ovf_reg   <= 1'b0;
                dup_reg   <= 1'b0;
            end
            else
            begin
                if (do_insert)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (status.new_pos)
                    begin
                        posc_reg <= posc_reg + 1'b1;
                    end
                end
                if (cmd.insert && status.full)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.emit)
                begin
                    dup_reg <= dup_now;
                end
            end
            if (cmd.clear_step)
            begin
                step_reg <= '0;
            end
            else if (cmd.rotate)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    assign status.full      = (count_reg == CW'(MAX_ITEMS));
    assign status.posc_zero = (posc_reg == '0);
    assign status.new_pos   = !item_value[VALUE_W-1];
    assign status.skip_last = (CW'(step_reg + 1'b1) == posc_reg);
    assign status.emit_last = (CW'(step_reg + 1'b1) == count_reg);

    assign result_valid     = valid_out_reg;
    assign sorted_value     = value_out_reg;
    assign arrival_position = pos_out_reg;
    assign run_end          = run_end_reg;
    assign duplicate_found  = dup_out_reg;
    assign overflow         = ovf_out_reg;

`ifndef SYNTHESIS
    a_emit_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> vld_reg[0])
        else $error("emit with empty chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_posc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        posc_reg <= count_reg)
        else $error("non-negative count exceeds item count");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_reg) == 32'(count_reg))
        else $error("valid cells disagree with item count");
`endif

endmodule

### rtl/core/sort_values_find_duplicate.sv
// ----------------------------------------------------------------------------
// sort_values_find_duplicate
// Loads a set of 64-bit values, sorts them (signed or unsigned), emits each
// with its arrival position and flags duplicates and overflow on the last.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  request  | start / busy            | item_value, set_end
//  result   | result_valid (strobe)   | sorted_value, arrival_position,
//           |                         | run_end, duplicate_found, overflow
//  config   | cfg_write               | cfg_data (signed_order)
//
//  Loading takes one request per cycle while busy is low; the insertion chain
//  places each value in the cycle it is accepted. After set_end, busy stays
//  high while the chain rotates once per cycle, first past the z non-negative
//  values when signed_order is 1, then once for each of the n stored values;
//  results follow one per cycle, each in the cycle after its rotation step, and
//  cannot be stalled. Reset leaves the chain empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sort_values_find_duplicate
#(
    parameter int MAX_ITEMS = svfd_pkg::MAX_ITEMS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [svfd_pkg::VALUE_W-1:0]  item_value,
    input  logic                          set_end,
    input  logic                          cfg_write,
    input  logic                          cfg_data,
    output logic                          result_valid,
    output logic [svfd_pkg::VALUE_W-1:0]  sorted_value,
    output logic [svfd_pkg::POS_W-1:0]    arrival_position,
    output logic                          run_end,
    output logic                          duplicate_found,
    output logic                          overflow
);
    import svfd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    svfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .set_end   (set_end),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    svfd_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_value       (item_value),
        .cmd              (cmd),
        .status           (status),
        .result_valid     (result_valid),
        .sorted_value     (sorted_value),
        .arrival_position (arrival_position),
        .run_end          (run_end),
        .duplicate_found  (duplicate_found),
        .overflow         (overflow)
    );

endmodule
